>>> design/arrig_pkg.sv
// ----------------------------------------------------------------------------
// arrig_pkg
// Word types and register codes of the rotate/reverse index generator.
// ----------------------------------------------------------------------------
`default_nettype none
package arrig_pkg;

  localparam logic CFG_AXIS_LENGTH  = 1'b0;
  localparam logic CFG_INNER_LENGTH = 1'b1;

  localparam logic MODE_REVERSE = 1'b0;
  localparam logic MODE_ROTATE  = 1'b1;

  localparam int IDX_W = 48;
  localparam int CFG_W = 17;

  typedef struct packed {
    logic               mode;
    logic [15:0]        outer_pos;
    logic [15:0]        axis_pos;
    logic [15:0]        inner_pos;
    logic signed [63:0] shift_amount;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] dst_index;
    logic [IDX_W-1:0] src_index;
  } out_word_t;

endpackage
`default_nettype wire

>>> design/arrig_rem_step.sv
// ----------------------------------------------------------------------------
// arrig_rem_step
// One registered bit step of the two remainder chains (shift and position).
// ----------------------------------------------------------------------------
`default_nettype none
module arrig_rem_step #(
  parameter int STEP  = 0,
  parameter int CW    = 16,
  parameter int LEN_W = 17
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [LEN_W-1:0] alen_i,
  input  wire logic             valid_i,
  input  wire logic             rot_i,
  input  wire logic             neg_i,
  input  wire logic [CW-1:0]    o_i,
  input  wire logic [CW-1:0]    a_i,
  input  wire logic [CW-1:0]    i_i,
  input  wire logic [63:0]      mag_i,
  input  wire logic [LEN_W-1:0] rs_i,
  input  wire logic [LEN_W-1:0] ra_i,
  output logic                  valid_o,
  output logic                  rot_o,
  output logic                  neg_o,
  output logic [CW-1:0]         o_o,
  output logic [CW-1:0]         a_o,
  output logic [CW-1:0]         i_o,
  output logic [63:0]           mag_o,
  output logic [LEN_W-1:0]      rs_o,
  output logic [LEN_W-1:0]      ra_o
);

  localparam int BIT = 63 - STEP;

  logic             a_bit;
  logic [LEN_W:0]   ts;
  logic [LEN_W:0]   ta;
  logic [LEN_W-1:0] rs_d;
  logic [LEN_W-1:0] ra_d;
  logic             valid_q;

  always_comb begin
    a_bit = (BIT < CW) ? a_i[BIT % CW] : 1'b0;
    ts = {rs_i, mag_i[BIT]};
    ta = {ra_i, a_bit};
    if (ts >= {1'b0, alen_i}) begin
      ts = ts - {1'b0, alen_i};
    end
    if (ta >= {1'b0, alen_i}) begin
      ta = ta - {1'b0, alen_i};
    end
    rs_d = ts[LEN_W-1:0];
    ra_d = ta[LEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_o <= rot_i;
      neg_o <= neg_i;
      o_o   <= o_i;
      a_o   <= a_i;
      i_o   <= i_i;
      mag_o <= mag_i;
      rs_o  <= rs_d;
      ra_o  <= ra_d;
    end
  end

  assign valid_o = valid_q;

endmodule
`default_nettype wire

>>> design/axis_rotate_reverse_index_gen_unit.sv
// ----------------------------------------------------------------------------
// axis_rotate_reverse_index_gen_unit
// Destination and source index generator for rotate/reverse along an axis.
// ----------------------------------------------------------------------------
// Usage: write axis_length and inner_length through cfg_we_i/cfg_idx_i/
// cfg_data_i while no word is in flight. Each input word (valid/stall)
// names a destination element; the output word carries its linear index
// and the index of the source element to copy.
// Throughput: one word per cycle while the output does not stall. Stages: the
// 64-step bit-serial remainder chain for the 64-bit shift (one bit per stage),
// plus capture, adjust, two multiply stages, an add stage and the final
// index add.
// Reset clears all valid bits and sets both lengths to 1.
// A stall at the output while out_valid_o is high freezes the whole pipeline;
// in_stall_o rises in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module axis_rotate_reverse_index_gen_unit #(
  parameter int DIM_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [arrig_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire arrig_pkg::in_word_t               in_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output arrig_pkg::out_word_t                   out_word_o
);

  localparam int CW    = DIM_BITS;
  localparam int LEN_W = DIM_BITS + 1;
  localparam int P_W   = CW + LEN_W;
  localparam int IW    = arrig_pkg::IDX_W;
  localparam int NS    = 64;
  localparam logic [32:0] LEN_MAX = 33'(1) << CW;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [arrig_pkg::CFG_W-1:0] v);
    logic [32:0] vw;
    vw = {16'b0, v};
    if (vw == 33'd0) begin
      return LEN_W'(1);
    end else if (vw > LEN_MAX) begin
      return LEN_MAX[LEN_W-1:0];
    end
    return vw[LEN_W-1:0];
  endfunction

  logic [LEN_W-1:0] alen_q;
  logic [LEN_W-1:0] ilen_q;
  logic             en;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alen_q <= LEN_W'(1);
      ilen_q <= LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        arrig_pkg::CFG_AXIS_LENGTH:  alen_q <= clamp_len(cfg_data_i);
        arrig_pkg::CFG_INNER_LENGTH: ilen_q <= clamp_len(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic             v_s   [0:NS];
  logic             rot_s [0:NS];
  logic             neg_s [0:NS];
  logic [CW-1:0]    o_s   [0:NS];
  logic [CW-1:0]    a_s   [0:NS];
  logic [CW-1:0]    i_s   [0:NS];
  logic [63:0]      mag_s [0:NS];
  logic [LEN_W-1:0] rs_s  [0:NS];
  logic [LEN_W-1:0] ra_s  [0:NS];

  logic [31:0] o_ext;
  logic [31:0] a_ext;
  logic [31:0] i_ext;
  logic        v0_q;

  assign o_ext = {16'b0, in_word_i.outer_pos};
  assign a_ext = {16'b0, in_word_i.axis_pos};
  assign i_ext = {16'b0, in_word_i.inner_pos};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_s[0] <= in_word_i.mode == arrig_pkg::MODE_ROTATE;
      neg_s[0] <= in_word_i.shift_amount[63];
      o_s[0]   <= o_ext[CW-1:0];
      a_s[0]   <= a_ext[CW-1:0];
      i_s[0]   <= i_ext[CW-1:0];
      mag_s[0] <= in_word_i.shift_amount[63] ? 64'(-in_word_i.shift_amount)
                                              : 64'(in_word_i.shift_amount);
      rs_s[0]  <= '0;
      ra_s[0]  <= '0;
    end
  end

  assign v_s[0] = v0_q;

  for (genvar k = 0; k < NS; k++) begin : g_step
    arrig_rem_step #(.STEP(k), .CW(CW), .LEN_W(LEN_W)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .alen_i  (alen_q),
      .valid_i (v_s[k]),
      .rot_i   (rot_s[k]),
      .neg_i   (neg_s[k]),
      .o_i     (o_s[k]),
      .a_i     (a_s[k]),
      .i_i     (i_s[k]),
      .mag_i   (mag_s[k]),
      .rs_i    (rs_s[k]),
      .ra_i    (ra_s[k]),
      .valid_o (v_s[k+1]),
      .rot_o   (rot_s[k+1]),
      .neg_o   (neg_s[k+1]),
      .o_o     (o_s[k+1]),
      .a_o     (a_s[k+1]),
      .i_o     (i_s[k+1]),
      .mag_o   (mag_s[k+1]),
      .rs_o    (rs_s[k+1]),
      .ra_o    (ra_s[k+1])
    );
  end

  // adjust stage
  logic [LEN_W-1:0] r_rot;
  logic [LEN_W:0]   sum;
  logic [LEN_W:0]   sum_red;
  logic [LEN_W-1:0] spos_d;
  logic             ve_q;
  logic [CW-1:0]    oe_q, ae_q, ie_q;
  logic [LEN_W-1:0] spos_q;

  always_comb begin
    r_rot   = (neg_s[NS] && rs_s[NS] != '0) ? alen_q - rs_s[NS] : rs_s[NS];
    sum     = {1'b0, r_rot} + {1'b0, ra_s[NS]};
    sum_red = (sum >= {1'b0, alen_q}) ? sum - {1'b0, alen_q} : sum;
    spos_d  = rot_s[NS] ? sum_red[LEN_W-1:0] : alen_q - LEN_W'(1) - ra_s[NS];
  end

  // multiply, add, multiply, add
  logic             vm_q, va_q, vn_q, vf_q;
  logic [P_W-1:0]   od_q;
  logic [CW-1:0]    am_q, im_q, ia_q, in_q;
  logic [LEN_W-1:0] sm_q;
  logic [IW-1:0]    dl_q, sl_q, dp_q, sp_q;
  logic [P_W+IW-1:0] od_ext;
  logic [CW+IW-1:0]  am_ext, sm_ext, in_ext;
  logic [IW+LEN_W-1:0] dp_full, sp_full;
  arrig_pkg::out_word_t out_q;

  assign od_ext  = {{IW{1'b0}}, od_q};
  assign am_ext  = {{IW{1'b0}}, am_q};
  assign sm_ext  = {{IW{1'b0}}, sm_q[CW-1:0]};
  assign in_ext  = {{IW{1'b0}}, in_q};
  assign dp_full = dl_q * ilen_q;
  assign sp_full = sl_q * ilen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vm_q <= 1'b0;
      va_q <= 1'b0;
      vn_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      ve_q <= v_s[NS];
      vm_q <= ve_q;
      va_q <= vm_q;
      vn_q <= va_q;
      vf_q <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oe_q   <= o_s[NS];
      ae_q   <= a_s[NS];
      ie_q   <= i_s[NS];
      spos_q <= spos_d;
      od_q   <= oe_q * alen_q;
      am_q   <= ae_q;
      sm_q   <= spos_q;
      im_q   <= ie_q;
      dl_q   <= od_ext[IW-1:0] + am_ext[IW-1:0];
      sl_q   <= od_ext[IW-1:0] + sm_ext[IW-1:0];
      ia_q   <= im_q;
      dp_q   <= dp_full[IW-1:0];
      sp_q   <= sp_full[IW-1:0];
      in_q   <= ia_q;
      out_q.dst_index <= dp_q + in_ext[IW-1:0];
      out_q.src_index <= sp_q + in_ext[IW-1:0];
    end
  end

  assign out_valid_o = vf_q;
  assign out_word_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alen_q != '0 && {{(33-LEN_W){1'b0}}, alen_q} <= LEN_MAX)
    else $error("axis length out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ilen_q != '0 && {{(33-LEN_W){1'b0}}, ilen_q} <= LEN_MAX)
    else $error("inner length out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_s[NS] |-> (rs_s[NS] < alen_q && ra_s[NS] < alen_q))
    else $error("remainder not below axis length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ve_q |-> spos_q < alen_q)
    else $error("source position not below axis length");

endmodule
`default_nettype wire

>>> bench/tb_axis_rotate_reverse_index_gen_unit.sv
// ----------------------------------------------------------------------------
// tb_axis_rotate_reverse_index_gen_unit
// Self-checking bench for the rotate/reverse index generator. Words are
// queued by a stimulus process, driven with random gaps, and every output
// word is compared with indices computed here from the current lengths.
// Several length settings are visited, including the saturation cases.
// ----------------------------------------------------------------------------
module tb_axis_rotate_reverse_index_gen_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_BITS = 16;
  localparam int LATENCY = 70;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic [arrig_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  arrig_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  arrig_pkg::out_word_t out_word;

  axis_rotate_reverse_index_gen_unit #(.DIM_BITS(DIM_BITS)) dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_word_i(in_word), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_word_o(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  arrig_pkg::in_word_t pending_words[$];
  arrig_pkg::out_word_t expected_indices[$];
  logic [arrig_pkg::CFG_W-1:0] axis_len_reg = 17'd1;
  logic [arrig_pkg::CFG_W-1:0] inner_len_reg = 17'd1;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int idle_cycles = 0;

  function automatic logic [16:0] clamp_length(logic [arrig_pkg::CFG_W-1:0] v);
    if (v == 0) return 17'd1;
    if (v > (17'd1 << DIM_BITS)) return 17'd1 << DIM_BITS;
    return v;
  endfunction

  function automatic arrig_pkg::out_word_t compute_indices(arrig_pkg::in_word_t w);
    logic [63:0] alen, ilen, o, a, i, pos, r, src, mag;
    arrig_pkg::out_word_t res;
    alen = 64'(clamp_length(axis_len_reg));
    ilen = 64'(clamp_length(inner_len_reg));
    o = 64'(w.outer_pos);
    a = 64'(w.axis_pos);
    i = 64'(w.inner_pos);
    pos = a % alen;
    if (w.mode == arrig_pkg::MODE_ROTATE) begin
      if (w.shift_amount[63]) begin
        mag = 64'd0 - w.shift_amount;
        r = mag % alen;
        r = (r != 0) ? alen - r : 64'd0;
      end else begin
        r = w.shift_amount % alen;
      end
      src = (r + pos) % alen;
    end else begin
      src = alen - 1 - pos;
    end
    res.dst_index = 48'((o * alen + a) * ilen + i);
    res.src_index = 48'((o * alen + src) * ilen + i);
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_indices.push_back(compute_indices(in_word));
        words_sent <= words_sent + 1;
        void'(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (pending_words.size() > (in_valid && !in_stall ? 0 : 0) &&
                   (calm || $urandom_range(99) >= 14) &&
                   pending_words.size() > 0) begin
        in_valid <= 1'b1;
        in_word <= pending_words[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        words_checked <= words_checked + 1;
        if (expected_indices.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected word %h", out_word);
        end else begin
          if (out_word.dst_index !== expected_indices[0].dst_index ||
              out_word.src_index !== expected_indices[0].src_index) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: dst exp %h got %h, src exp %h got %h",
                       expected_indices[0].dst_index, out_word.dst_index,
                       expected_indices[0].src_index, out_word.src_index);
          end
          void'(expected_indices.pop_front());
        end
      end
      out_stall <= hold_off || (!calm && $urandom_range(99) < 14);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout");
      $display("simulation failed");
      $finish;
    end
  end

  function automatic arrig_pkg::in_word_t random_word(int pick);
    arrig_pkg::in_word_t w;
    logic [63:0] sh;
    w.mode = 1'($urandom_range(1));
    w.outer_pos = (pick < 3) ? 16'($urandom_range(7)) : 16'($urandom);
    w.axis_pos = (pick < 5) ? 16'($urandom_range(axis_len_reg)) : 16'($urandom);
    w.inner_pos = (pick < 5) ? 16'($urandom_range(inner_len_reg)) : 16'($urandom);
    sh = {$urandom, $urandom};
    case (pick % 4)
      0: sh = 64'($signed($urandom_range(40)) - 20);
      1: sh = {{32{sh[31]}}, sh[31:0]};
      default: ;
    endcase
    w.shift_amount = sh;
    return w;
  endfunction

  task automatic drain_and_write(logic idx, logic [arrig_pkg::CFG_W-1:0] value);
    while (pending_words.size() > 0 || in_valid || expected_indices.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == arrig_pkg::CFG_AXIS_LENGTH) axis_len_reg = value;
    else inner_len_reg = value;
  endtask

  task automatic queue_word(logic m, logic [15:0] o, logic [15:0] a, logic [15:0] i,
                            logic [63:0] sh);
    arrig_pkg::in_word_t w;
    w.mode = m;
    w.outer_pos = o;
    w.axis_pos = a;
    w.inner_pos = i;
    w.shift_amount = sh;
    pending_words.push_back(w);
  endtask

  logic [arrig_pkg::CFG_W-1:0] axis_settings[8] = '{17'd5, 17'd0, 17'd1, 17'd65536,
                                                    17'h1FFFF, 17'd7, 17'd300, 17'd65535};
  logic [arrig_pkg::CFG_W-1:0] inner_settings[8] = '{17'd3, 17'd1, 17'd0, 17'd65536,
                                                     17'h1FFFF, 17'd11, 17'd2, 17'd65535};

  initial begin
    int hold_len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed words on reset lengths, then on a small shape
    queue_word(arrig_pkg::MODE_REVERSE, 16'd0, 16'd0, 16'd0, 64'd0);
    queue_word(arrig_pkg::MODE_ROTATE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               64'h7FFF_FFFF_FFFF_FFFF);
    drain_and_write(arrig_pkg::CFG_AXIS_LENGTH, 17'd5);
    drain_and_write(arrig_pkg::CFG_INNER_LENGTH, 17'd3);
    queue_word(arrig_pkg::MODE_REVERSE, 16'd0, 16'd0, 16'd0, 64'd0);
    queue_word(arrig_pkg::MODE_REVERSE, 16'd2, 16'd4, 16'd2, 64'd9);
    queue_word(arrig_pkg::MODE_REVERSE, 16'd1, 16'd7, 16'd5, 64'd0);
    queue_word(arrig_pkg::MODE_ROTATE, 16'd1, 16'd3, 16'd1, 64'd2);
    queue_word(arrig_pkg::MODE_ROTATE, 16'd1, 16'd3, 16'd1, -64'sd2);
    queue_word(arrig_pkg::MODE_ROTATE, 16'd0, 16'd0, 16'd0, -64'sd5);
    queue_word(arrig_pkg::MODE_ROTATE, 16'd0, 16'd4, 16'd0, 64'h8000_0000_0000_0000);
    queue_word(arrig_pkg::MODE_ROTATE, 16'd0, 16'd4, 16'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_word(arrig_pkg::MODE_ROTATE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(arrig_pkg::MODE_ROTATE, 16'd3, 16'd9, 16'd8, 64'd5);
    for (int s = 0; s < 8; s++) begin
      drain_and_write(arrig_pkg::CFG_AXIS_LENGTH, axis_settings[s]);
      drain_and_write(arrig_pkg::CFG_INNER_LENGTH, inner_settings[s]);
      calm = (s == 3);
      queue_word(arrig_pkg::MODE_REVERSE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 64'd0);
      queue_word(arrig_pkg::MODE_ROTATE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 64'h8000_0000_0000_0000);
      for (int n = 0; n < 210; n++) pending_words.push_back(random_word($urandom_range(9)));
      if (s == 2) begin
        // back-pressure: stop the receiver so the pipeline fills
        while (words_sent < 10) @(posedge clk);
        hold_off = 1'b1;
        hold_len = 0;
        while (hold_len < 300) begin
          @(posedge clk);
          hold_len++;
        end
        hold_off = 1'b0;
      end
    end
    while (pending_words.size() > 0 || in_valid || expected_indices.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d words over reset and 8 length settings incl. zero and saturated",
             words_checked);
    $display("both modes, extreme shifts and out-of-range coordinates; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_indices.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
